// File: rtl/lsrl_pkg.sv
// Shared types, codes and constants of the lowpass slew-rate limiter.
package lsrl_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ADDR_WIDTH = 5;

    localparam logic [2:0] REG_BLEND_GAIN    = 3'd0;
    localparam logic [2:0] REG_FB_GAIN       = 3'd1;
    localparam logic [2:0] REG_SLEW_LIMIT    = 3'd2;
    localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd3;
    localparam logic [2:0] REG_SAMPLE_RATE   = 3'd4;

    localparam logic [15:0] RST_BLEND_GAIN    = 16'd0;
    localparam logic [30:0] RST_FB_GAIN       = 31'd0;
    localparam logic [30:0] RST_SLEW_LIMIT    = 31'h7FFF_FFFF;
    localparam logic [31:0] RST_SAMPLE_PERIOD = 32'd0;
    localparam logic [20:0] RST_SAMPLE_RATE   = 21'd1000;

    typedef struct packed {
        logic [15:0] blend_gain;
        logic [30:0] fb_gain;
        logic [30:0] slew_limit;
        logic [31:0] sample_period;
        logic [20:0] sample_rate;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LPF,
        ST_SMOOTH,
        ST_MUL_RATE,
        ST_MUL_FB,
        ST_CMD,
        ST_MUL_PERIOD,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MUL_LPF,
        OP_SMOOTH,
        OP_MUL_RATE,
        OP_MUL_FB,
        OP_CMD,
        OP_MUL_PERIOD,
        OP_UPDATE
    } t_dp_op;

    typedef struct packed {
        logic   load;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_status;

endpackage

// File: rtl/lowpass_slew_rate_limiter.sv
// Top level of the lowpass slew-rate limiter.
//
// Requests enter on i_in_valid / o_in_stall with i_mode and i_sample.
// Mode 0 filters a signed Q16.16 sample; mode 1 clears the output and the
// stored smoothed value and returns zero. Each request yields one result
// on o_out_valid / i_out_stall carrying o_filtered.
// A filter request runs through seven steps on one shared 33 by 33 bit
// multiplier: lowpass product, smoothing add, rate product, feedback
// product, velocity clamp, period product and the saturating update.
// The update step writes the result into the output register, and the
// next request is accepted in the cycle of the update; a clear request
// skips the arithmetic and goes straight to the update step.
// Results sit in an output register, so a new request can start while the
// previous result waits; the update step holds while that register is
// full and stalled, and the input stalls with it.
// Reset clears the valid flag, the fed-back output and the stored smoothed
// value and resets all registers. The registers are written through the
// APB-style port and must only change while no request is in flight.
module lowpass_slew_rate_limiter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lsrl_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic [lsrl_pkg::DATA_WIDTH-1:0] i_sample,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [lsrl_pkg::DATA_WIDTH-1:0] o_filtered
);

    lsrl_pkg::t_cfg       w_cfg;
    lsrl_pkg::t_dp_cmd    w_cmd;
    lsrl_pkg::t_dp_status w_status;

    lsrl_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lsrl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lsrl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_mode      (i_mode),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_filtered  (o_filtered)
    );

endmodule

// File: rtl/lsrl_regs.sv
// Configuration register file behind the APB-style port.
module lsrl_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lsrl_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output lsrl_pkg::t_cfg                 o_cfg
);

    lsrl_pkg::t_cfg r_cfg;
    logic           w_write;
    logic [2:0]     w_index;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;
    assign w_index = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blend_gain    <= lsrl_pkg::RST_BLEND_GAIN;
            r_cfg.fb_gain       <= lsrl_pkg::RST_FB_GAIN;
            r_cfg.slew_limit    <= lsrl_pkg::RST_SLEW_LIMIT;
            r_cfg.sample_period <= lsrl_pkg::RST_SAMPLE_PERIOD;
            r_cfg.sample_rate   <= lsrl_pkg::RST_SAMPLE_RATE;
        end else if (w_write) begin
            case (w_index)
                lsrl_pkg::REG_BLEND_GAIN:    r_cfg.blend_gain    <= pwdata[15:0];
                lsrl_pkg::REG_FB_GAIN:       r_cfg.fb_gain       <= pwdata[30:0];
                lsrl_pkg::REG_SLEW_LIMIT:    r_cfg.slew_limit    <= pwdata[30:0];
                lsrl_pkg::REG_SAMPLE_PERIOD: r_cfg.sample_period <= pwdata;
                lsrl_pkg::REG_SAMPLE_RATE:   r_cfg.sample_rate   <= pwdata[20:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            lsrl_pkg::REG_BLEND_GAIN:    prdata = {16'd0, r_cfg.blend_gain};
            lsrl_pkg::REG_FB_GAIN:       prdata = {1'b0, r_cfg.fb_gain};
            lsrl_pkg::REG_SLEW_LIMIT:    prdata = {1'b0, r_cfg.slew_limit};
            lsrl_pkg::REG_SAMPLE_PERIOD: prdata = r_cfg.sample_period;
            lsrl_pkg::REG_SAMPLE_RATE:   prdata = {11'd0, r_cfg.sample_rate};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/lsrl_ctrl.sv
// Sequencer that steps the datapath through one request.
module lsrl_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_mode,
    output logic                 o_in_stall,
    input  lsrl_pkg::t_dp_status i_status,
    output lsrl_pkg::t_dp_cmd    o_cmd
);

    lsrl_pkg::t_state r_state;
    lsrl_pkg::t_state n_state;
    logic             w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsrl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        o_cmd.load = 1'b0;
        o_cmd.op   = lsrl_pkg::OP_NONE;
        case (r_state)
            lsrl_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            lsrl_pkg::ST_MUL_LPF: begin
                o_cmd.op = lsrl_pkg::OP_MUL_LPF;
                n_state  = lsrl_pkg::ST_SMOOTH;
            end
            lsrl_pkg::ST_SMOOTH: begin
                o_cmd.op = lsrl_pkg::OP_SMOOTH;
                n_state  = lsrl_pkg::ST_MUL_RATE;
            end
            lsrl_pkg::ST_MUL_RATE: begin
                o_cmd.op = lsrl_pkg::OP_MUL_RATE;
                n_state  = lsrl_pkg::ST_MUL_FB;
            end
            lsrl_pkg::ST_MUL_FB: begin
                o_cmd.op = lsrl_pkg::OP_MUL_FB;
                n_state  = lsrl_pkg::ST_CMD;
            end
            lsrl_pkg::ST_CMD: begin
                o_cmd.op = lsrl_pkg::OP_CMD;
                n_state  = lsrl_pkg::ST_MUL_PERIOD;
            end
            lsrl_pkg::ST_MUL_PERIOD: begin
                o_cmd.op = lsrl_pkg::OP_MUL_PERIOD;
                n_state  = lsrl_pkg::ST_DONE;
            end
            lsrl_pkg::ST_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.op   = lsrl_pkg::OP_UPDATE;
                    o_in_stall = 1'b0;
                    n_state    = lsrl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lsrl_pkg::ST_IDLE;
            end
        endcase
        if (i_in_valid && !o_in_stall) begin
            o_cmd.load = 1'b1;
            n_state    = i_mode ? lsrl_pkg::ST_DONE : lsrl_pkg::ST_MUL_LPF;
        end
    end

    assign w_accept = i_in_valid && !o_in_stall;

    a_clear_skips_math: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_mode |=> r_state == lsrl_pkg::ST_DONE)
        else $error("clear request did not go straight to the update step");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != lsrl_pkg::ST_IDLE && r_state != lsrl_pkg::ST_DONE |-> o_in_stall)
        else $error("request accepted while the datapath is busy");

endmodule

// File: rtl/lsrl_dp.sv
// Datapath: shared multiplier, filter state and the output register.
module lsrl_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lsrl_pkg::t_cfg                 i_cfg,
    input  lsrl_pkg::t_dp_cmd              i_cmd,
    output lsrl_pkg::t_dp_status           o_status,
    input  logic                           i_mode,
    input  logic [lsrl_pkg::DATA_WIDTH-1:0] i_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [lsrl_pkg::DATA_WIDTH-1:0] o_filtered
);

    localparam logic signed [34:0] OUT_MAX = 35'sh0_7FFF_FFFF;
    localparam logic signed [34:0] OUT_MIN = 35'sh7_8000_0000;

    logic               r_clr;
    logic        [31:0] r_x;
    logic        [31:0] r_y;
    logic        [31:0] r_prev;
    logic        [31:0] r_sm;
    logic signed [55:0] r_rate;
    logic signed [31:0] r_cmd;
    logic signed [65:0] r_prod;
    logic               r_out_valid;
    logic        [31:0] r_out;

    logic signed [32:0] w_mul_a;
    logic signed [32:0] w_mul_b;
    logic signed [65:0] w_mul_p;
    logic signed [32:0] w_diff_xy;
    logic signed [32:0] w_diff_sm;
    logic signed [32:0] w_diff_ys;
    logic signed [33:0] w_sm_sum;
    logic signed [47:0] w_fb_term;
    logic signed [56:0] w_cmd_raw;
    logic signed [56:0] w_vmax;
    logic signed [56:0] w_vmin;
    logic signed [31:0] w_cmd_clamped;
    logic signed [33:0] w_step;
    logic signed [34:0] w_out_sum;
    logic        [31:0] w_out_sat;

    assign w_diff_xy = {r_x[31], r_x} - {r_y[31], r_y};
    assign w_diff_sm = {r_sm[31], r_sm} - {r_prev[31], r_prev};
    assign w_diff_ys = {r_y[31], r_y} - {r_sm[31], r_sm};

    always_comb begin
        case (i_cmd.op)
            lsrl_pkg::OP_MUL_LPF: begin
                w_mul_a = w_diff_xy;
                w_mul_b = {17'd0, i_cfg.blend_gain};
            end
            lsrl_pkg::OP_MUL_RATE: begin
                w_mul_a = w_diff_sm;
                w_mul_b = {12'd0, i_cfg.sample_rate};
            end
            lsrl_pkg::OP_MUL_FB: begin
                w_mul_a = w_diff_ys;
                w_mul_b = {2'd0, i_cfg.fb_gain};
            end
            lsrl_pkg::OP_MUL_PERIOD: begin
                w_mul_a = {r_cmd[31], r_cmd};
                w_mul_b = {1'b0, i_cfg.sample_period};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p  = w_mul_a * w_mul_b;
    assign w_sm_sum = {{2{r_y[31]}}, r_y} + r_prod[49:16];

    assign w_fb_term = r_prod[63:16];
    assign w_cmd_raw = {r_rate[55], r_rate} - {{9{w_fb_term[47]}}, w_fb_term};
    assign w_vmax    = {26'd0, i_cfg.slew_limit};
    assign w_vmin    = -w_vmax;

    always_comb begin
        if (w_cmd_raw > w_vmax) begin
            w_cmd_clamped = w_vmax[31:0];
        end else if (w_cmd_raw < w_vmin) begin
            w_cmd_clamped = w_vmin[31:0];
        end else begin
            w_cmd_clamped = w_cmd_raw[31:0];
        end
    end

    assign w_step    = r_prod[65:32];
    assign w_out_sum = {{3{r_y[31]}}, r_y} + {w_step[33], w_step};

    always_comb begin
        if (w_out_sum > OUT_MAX) begin
            w_out_sat = OUT_MAX[31:0];
        end else if (w_out_sum < OUT_MIN) begin
            w_out_sat = OUT_MIN[31:0];
        end else begin
            w_out_sat = w_out_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_clr <= i_mode;
            r_x   <= i_sample;
        end
        case (i_cmd.op)
            lsrl_pkg::OP_MUL_LPF,
            lsrl_pkg::OP_MUL_RATE,
            lsrl_pkg::OP_MUL_PERIOD: begin
                r_prod <= w_mul_p;
            end
            lsrl_pkg::OP_MUL_FB: begin
                r_prod <= w_mul_p;
                r_rate <= r_prod[55:0];
            end
            lsrl_pkg::OP_SMOOTH: begin
                r_sm <= w_sm_sum[31:0];
            end
            lsrl_pkg::OP_CMD: begin
                r_cmd <= w_cmd_clamped;
            end
            lsrl_pkg::OP_UPDATE: begin
                r_out <= r_clr ? 32'd0 : w_out_sat;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y         <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == lsrl_pkg::OP_UPDATE) begin
                r_y         <= r_clr ? 32'd0 : w_out_sat;
                r_prev      <= r_clr ? 32'd0 : r_sm;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_filtered        = r_out;

    a_update_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == lsrl_pkg::OP_UPDATE |=> r_out_valid)
        else $error("update step did not present a result");

    a_update_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == lsrl_pkg::OP_UPDATE |-> !(r_out_valid && i_out_stall))
        else $error("update step overwrote a result still waiting");

    a_cmd_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == lsrl_pkg::OP_CMD |=>
            ($signed({r_cmd[31], r_cmd}) <= $signed({2'b0, i_cfg.slew_limit}))
            && ($signed({r_cmd[31], r_cmd}) >= -$signed({2'b0, i_cfg.slew_limit})))
        else $error("velocity command exceeds the configured limit");

endmodule
